[rtl/core/scsf_pkg.sv]
// Shared types and constants for the int8 class score seed filter.
// No dependencies; imported by the core and the result queue.
package scsf_pkg;

  // Tensor limits
  localparam int MAX_ANCHORS = 65536;
  localparam int MAX_CLASSES = 256;
  localparam logic [16:0] ANCHOR_LIMIT = 17'(MAX_ANCHORS);
  localparam logic [8:0]  CLASS_LIMIT  = 9'(MAX_CLASSES);

  // Probability table geometry
  localparam int TABLE_AW = 8;
  localparam int PROB_W   = 16;

  // Scan counter limits (saturation)
  localparam logic [16:0] ANCHOR_SCAN_MAX = '1;
  localparam logic [24:0] VALUE_SCAN_MAX  = '1;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOGIT_PASS_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUM_PASS_MIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_CAPACITY  = 2'd2;

  localparam logic signed [8:0] LOGIT_PASS_MIN_RST = 9'sd128;
  localparam logic signed [7:0] SUM_PASS_MIN_RST   = 8'sh80;
  localparam logic [15:0]       SEED_CAPACITY_RST  = 16'hFFFF;

  // Command and result codes
  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_ELEMENT     = 1'b1;
  localparam logic RES_SEED        = 1'b0;
  localparam logic RES_SUMMARY     = 1'b1;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef struct packed {
    logic               command;
    logic [15:0]        anchor_index;
    logic [7:0]         class_index;
    logic signed [7:0]  logit_value;
    logic signed [7:0]  score_sum_value;
    logic [15:0]        table_data;
    logic               frame_start;
    logic               frame_end;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] seed_anchor;
    logic [7:0]  seed_class;
    logic [15:0] probability;
    logic [15:0] seed_total;
    logic        status;
    logic [16:0] anchor_scan_count;
    logic [24:0] value_scan_count;
    logic        last_result;
  } result_t;

  // One item's pending results: a seed, a summary, or both
  typedef struct packed {
    logic        has_seed;
    logic        has_sum;
    logic [15:0] anchor;
    logic [7:0]  cls;
    logic [15:0] prob;
    logic [15:0] seed_total;
    logic        overflow;
    logic [16:0] anchor_scan;
    logic [24:0] value_scan;
  } pend_t;

endpackage

[rtl/core/int8_class_score_seed_filter_core.sv]
// Top level of the int8 class score seed filter.
// Depends on scsf_pkg, scsf_prob_ram and scsf_result_queue.

// Takes one beat per clock on the item channel: either a probability table
// load (command 0, entry address in logit_value, Q0.16 data in table_data) or
// one int8 logit element in anchor-major order. An element whose score sum
// clears sum_pass_min is counted as scanned (anchors on their class 0
// element); if its logit also clears logit_pass_min it becomes a seed with
// the table probability for that logit code, until seed_capacity seeds have
// been kept, after which seeds are dropped and overflow is flagged.
// frame_start clears the frame counts before the beat is handled; frame_end
// queues a summary after the beat's own seed. Sustained rate is one item per
// cycle; an item that yields both a seed and a summary occupies the result
// channel for two beats, so the item channel stalls while the four-entry
// result queue catches up. A result is registered with the synchronous
// table read in stage 1 and then in the result queue before it appears. The
// table sits in one RAM with one write and one read port; a load is written
// at its own beat edge, so a seed arriving on the very next beat already
// reads the new entry and no forwarding is needed. Table entries must be
// loaded before any seed reads them. Configuration writes belong between
// frames, with the block idle.
module int8_class_score_seed_filter_core (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [scsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // item channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  scsf_pkg::item_t                  item,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output scsf_pkg::result_t                result
);
  import scsf_pkg::*;

  // Configuration registers
  logic signed [8:0] logit_pass_min;
  logic signed [7:0] sum_pass_min;
  logic [15:0]       seed_capacity;

  // Frame state
  logic [15:0] seed_count;
  logic        overflow_flag;
  logic [16:0] anchor_scan_total;
  logic [24:0] value_scan_total;

  logic [15:0] seed_count_next;
  logic        overflow_flag_next;
  logic [16:0] anchor_scan_total_next;
  logic [24:0] value_scan_total_next;

  // Accept-side decode
  logic        take;
  logic        is_elem;
  logic        in_range;
  logic        scanned;
  logic        seed_cand;
  logic        cap_hit;
  logic        emit_seed;
  logic [15:0] seed_base;
  logic        ovf_base;
  logic [16:0] anchor_base;
  logic [24:0] value_base;

  // Stage 1: waiting on the table read
  logic        s1_valid;
  pend_t       s1;
  pend_t       s1_push;
  logic [PROB_W-1:0] ram_rdata;

  logic [QUEUE_CW-1:0] q_count;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      logit_pass_min <= LOGIT_PASS_MIN_RST;
      sum_pass_min   <= SUM_PASS_MIN_RST;
      seed_capacity  <= SEED_CAPACITY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOGIT_PASS_MIN: logit_pass_min <= $signed(cfg_data[8:0]);
        CFG_SUM_PASS_MIN:   sum_pass_min   <= $signed(cfg_data[7:0]);
        CFG_SEED_CAPACITY:  seed_capacity  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Per-beat filtering and frame counts
  // ---------------------------------------------------------------------
  // Room for one more item: queue plus the entry in flight must stay below depth
  assign item_stall = (q_count + QUEUE_CW'(s1_valid)) >= QUEUE_CW'(QUEUE_DEPTH);
  assign take       = item_valid && !item_stall;

  always_comb begin
    // frame_start clears the counts before this beat is applied
    seed_base   = item.frame_start ? '0   : seed_count;
    ovf_base    = item.frame_start ? 1'b0 : overflow_flag;
    anchor_base = item.frame_start ? '0   : anchor_scan_total;
    value_base  = item.frame_start ? '0   : value_scan_total;

    is_elem   = (item.command == CMD_ELEMENT);
    in_range  = ({1'b0, item.anchor_index} < ANCHOR_LIMIT) &&
                ({1'b0, item.class_index} < CLASS_LIMIT);
    scanned   = is_elem && in_range && (item.score_sum_value >= sum_pass_min);
    seed_cand = scanned &&
                ($signed({item.logit_value[7], item.logit_value}) >= logit_pass_min);
    cap_hit   = (seed_base >= seed_capacity);
    emit_seed = seed_cand && !cap_hit;

    seed_count_next    = emit_seed ? seed_base + 16'd1 : seed_base;
    overflow_flag_next = ovf_base || (seed_cand && cap_hit);

    anchor_scan_total_next = anchor_base;
    if (scanned && (item.class_index == '0) && (anchor_base != ANCHOR_SCAN_MAX)) begin
      anchor_scan_total_next = anchor_base + 17'd1;
    end
    value_scan_total_next = value_base;
    if (scanned && (value_base != VALUE_SCAN_MAX)) begin
      value_scan_total_next = value_base + 25'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count        <= '0;
      overflow_flag     <= 1'b0;
      anchor_scan_total <= '0;
      value_scan_total  <= '0;
      s1_valid          <= 1'b0;
    end else begin
      if (take) begin
        seed_count        <= seed_count_next;
        overflow_flag     <= overflow_flag_next;
        anchor_scan_total <= anchor_scan_total_next;
        value_scan_total  <= value_scan_total_next;
      end
      // only beats that produce a result enter the pipe
      s1_valid <= take && (emit_seed || item.frame_end);
    end
  end

  // payload of stage 1, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      s1.has_seed    <= emit_seed;
      s1.has_sum     <= item.frame_end;
      s1.anchor      <= item.anchor_index;
      s1.cls         <= item.class_index;
      s1.prob        <= '0;
      s1.seed_total  <= seed_count_next;
      s1.overflow    <= overflow_flag_next;
      s1.anchor_scan <= anchor_scan_total_next;
      s1.value_scan  <= value_scan_total_next;
    end
  end

  // ---------------------------------------------------------------------
  // Probability table: load on table beats, read on seeds
  // ---------------------------------------------------------------------
  scsf_prob_ram #(
    .AW (TABLE_AW),
    .DW (PROB_W)
  ) u_prob_ram (
    .clk   (clk),
    .we    (take && (item.command == CMD_TABLE_WRITE)),
    .waddr (item.logit_value),
    .wdata (item.table_data),
    .re    (take && emit_seed),
    .raddr (item.logit_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_push      = s1;
    s1_push.prob = ram_rdata;
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  scsf_result_queue u_result_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (s1_valid),
    .push_data    (s1_push),
    .count        (q_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // stall accounting keeps a free slot for every entry in flight
  a_no_queue_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count < QUEUE_CW'(QUEUE_DEPTH)))
    else $error("result queue pushed while full");

  // a frame_end beat always produces a queued summary
  a_end_gives_summary: assert property (@(posedge clk) disable iff (rst)
    (take && item.frame_end) |=> (s1_valid && s1.has_sum))
    else $error("frame end beat without summary");

  // every scanned anchor is also a scanned value
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    ({8'd0, anchor_scan_total} <= value_scan_total))
    else $error("anchor scan count exceeds value scan count");

endmodule

[rtl/core/scsf_prob_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read data.
// Holds the probability table; no package dependencies.
module scsf_prob_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/scsf_result_queue.sv]
// Result queue: one entry per result-producing item, unrolled into seed and summary beats.
// Depends on scsf_pkg (pend_t, result_t, queue constants).
module scsf_result_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  scsf_pkg::pend_t               push_data,
  output logic [scsf_pkg::QUEUE_CW-1:0] count,
  output logic                          result_valid,
  input  logic                          result_stall,
  output scsf_pkg::result_t             result
);
  import scsf_pkg::*;

  pend_t               q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic                seed_done;
  pend_t               head;
  logic                show_seed;
  logic                last_beat;
  logic                beat;
  logic                pop;

  assign head         = q_mem[rd_ptr];
  assign result_valid = (count != '0);
  assign show_seed    = head.has_seed && !seed_done;
  assign last_beat    = !(show_seed && head.has_sum);
  assign beat         = result_valid && !result_stall;
  assign pop          = beat && last_beat;

  always_comb begin
    result = '0;
    if (show_seed) begin
      result.result_kind = RES_SEED;
      result.seed_anchor = head.anchor;
      result.seed_class  = head.cls;
      result.probability = head.prob;
    end else begin
      result.result_kind       = RES_SUMMARY;
      result.seed_total        = head.seed_total;
      result.status            = head.overflow;
      result.anchor_scan_count = head.anchor_scan;
      result.value_scan_count  = head.value_scan;
      result.last_result       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      seed_done <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr    <= rd_ptr + 1'b1;
        seed_done <= 1'b0;
      end else if (beat) begin
        seed_done <= 1'b1;
      end
      count <= count + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end
  end

endmodule
